>>> hw/rtl/spo2_pkg.sv
// Shared types and constants for the pulse-oximeter serial packet deframer.
// No dependencies.
package spo2_pkg;

    localparam int unsigned PACKET_LEN    = 5;
    localparam int unsigned MAX_STRENGTH  = 8;
    localparam int unsigned BYTES_LEFT_W  = 3;
    localparam int unsigned PKT_IDX_W     = 2;
    localparam int unsigned PKT_DEPTH     = 4;

    localparam logic CMD_RX_BYTE     = 1'b0;
    localparam logic CMD_PORT_CLOSED = 1'b1;

    typedef enum logic [2:0] {
        MODE_WAIT = 3'b001,
        MODE_READ = 3'b010,
        MODE_DISC = 3'b100
    } spo2_mode_t;

    typedef struct packed {
        logic [3:0]  sig_level;
        logic        beep_flag;
        logic        no_finger;
        logic [6:0]  pleth_sample;
        logic [7:0]  heart_rate;
        logic [6:0]  spo2_percent;
        logic [15:0] delta_ms;
    } spo2_res_t;

endpackage

>>> hw/rtl/spo2_frm.sv
// Framer: link mode, byte counter, packet byte store and packet decode.
// Depends on spo2_pkg.
module spo2_frm
    import spo2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        cmd,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    output logic        emit,
    output spo2_res_t   res
);

    spo2_mode_t              mode_reg, mode_next;
    logic [BYTES_LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]              pkt_reg [PKT_DEPTH];
    logic [7:0]              pkt_next [PKT_DEPTH];
    logic [31:0]             last_time_reg, last_time_next;
    logic                    start;
    logic [PKT_IDX_W-1:0]    pkt_idx;
    logic [3:0]              strength;

    assign start   = rx_byte[7];
    // bytes_left 4..2 maps to store slots 1..3
    assign pkt_idx = PKT_IDX_W'(BYTES_LEFT_W'(PACKET_LEN) - bytes_left_reg);

    always_comb begin
        mode_next       = mode_reg;
        bytes_left_next = bytes_left_reg;
        pkt_next        = pkt_reg;
        last_time_next  = last_time_reg;
        emit            = 1'b0;
        if (accept) begin
            if (cmd == CMD_PORT_CLOSED) begin
                mode_next = MODE_DISC;
            end else if (mode_reg != MODE_DISC) begin
                if (start) begin
                    // start byte always (re)opens a packet
                    pkt_next[0]     = rx_byte;
                    bytes_left_next = BYTES_LEFT_W'(PACKET_LEN - 1);
                    mode_next       = MODE_READ;
                end else if (mode_reg == MODE_READ) begin
                    if (bytes_left_reg >= BYTES_LEFT_W'(2) &&
                        bytes_left_reg <= BYTES_LEFT_W'(PACKET_LEN - 1)) begin
                        pkt_next[pkt_idx] = rx_byte;
                        bytes_left_next   = bytes_left_reg - BYTES_LEFT_W'(1);
                    end else begin
                        mode_next       = MODE_WAIT;
                        bytes_left_next = '0;
                        last_time_next  = now_ms;
                        emit            = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        strength = pkt_reg[0][3:0];
        if (strength > 4'(MAX_STRENGTH)) begin
            strength = 4'(MAX_STRENGTH);
        end
        res.sig_level    = strength;
        res.beep_flag    = pkt_reg[0][6];
        res.no_finger    = pkt_reg[2][4];
        res.pleth_sample = pkt_reg[1][6:0];
        res.heart_rate   = {pkt_reg[2][6], pkt_reg[3][6:0]};
        res.spo2_percent = rx_byte[6:0];
        res.delta_ms     = now_ms[15:0] - last_time_reg[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_WAIT;
            bytes_left_reg <= '0;
            last_time_reg  <= '0;
        end else begin
            mode_reg       <= mode_next;
            bytes_left_reg <= bytes_left_next;
            last_time_reg  <= last_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        pkt_reg <= pkt_next;
    end

    a_close_disc: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_PORT_CLOSED |=> mode_reg == MODE_DISC)
        else $error("port close did not reach disconnected mode");

    a_disc_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_DISC |=> mode_reg == MODE_DISC)
        else $error("left disconnected mode without reset");

    a_emit_read: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> mode_reg == MODE_READ && bytes_left_reg <= BYTES_LEFT_W'(1))
        else $error("packet emitted outside a packet tail");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= BYTES_LEFT_W'(PACKET_LEN - 1))
        else $error("byte counter out of range");

endmodule

>>> hw/rtl/spo2_obuf.sv
// Output register with skid stage for decoded packet results.
// Depends on spo2_pkg.
module spo2_obuf
    import spo2_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  spo2_res_t res_in,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output spo2_res_t m_res
);

    logic      main_valid_reg, skid_valid_reg;
    spo2_res_t main_reg, skid_reg;
    logic      pop;

    assign pop      = main_valid_reg && m_ready;
    assign in_ready = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_res    = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push && main_valid_reg && !pop) begin
            skid_valid_reg <= 1'b1;
        end else if (push) begin
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push && main_valid_reg && !pop) begin
            skid_reg <= res_in;
        end else if (push) begin
            main_reg <= res_in;
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds data with empty output register");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        push && main_valid_reg && !pop |=> skid_valid_reg)
        else $error("result dropped while output stalled");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && pop |=> main_valid_reg && !skid_valid_reg)
        else $error("skid stage did not drain into output register");

endmodule

>>> hw/rtl/spo2_serial_packet_deframer.sv
// Pulse-oximeter serial packet deframer, top level.
// Depends on spo2_pkg, spo2_frm and spo2_obuf.
//
// One serial byte (or a port-closed event) is taken per transfer, one per
// clock cycle while s_ready is high; a completed 5-byte packet is registered
// for the m_ channel when its last byte is taken. The framer updates its
// state in the cycle a byte is taken, and results sit in a two-entry output
// register, so input keeps flowing at one byte per cycle while m_ready is
// high and through a single stalled result; s_ready drops only when two
// results wait. After a port-closed event all bytes are dropped until reset.
module spo2_serial_packet_deframer
    import spo2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_sig_level,
    output logic        m_beep_flag,
    output logic        m_no_finger,
    output logic [6:0]  m_pleth_sample,
    output logic [7:0]  m_heart_rate,
    output logic [6:0]  m_spo2_percent,
    output logic [15:0] m_delta_ms
);

    logic      accept;
    logic      emit;
    spo2_res_t res;
    spo2_res_t m_res;

    assign accept = s_valid && s_ready;

    spo2_frm u_frm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cmd     (s_cmd),
        .rx_byte (s_rx_byte),
        .now_ms  (s_now_ms),
        .emit    (emit),
        .res     (res)
    );

    spo2_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (emit),
        .res_in   (res),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_sig_level    = m_res.sig_level;
    assign m_beep_flag    = m_res.beep_flag;
    assign m_no_finger    = m_res.no_finger;
    assign m_pleth_sample = m_res.pleth_sample;
    assign m_heart_rate   = m_res.heart_rate;
    assign m_spo2_percent = m_res.spo2_percent;
    assign m_delta_ms     = m_res.delta_ms;

endmodule
